>>> rtl/dkbs_pkg.sv
// Shared types, constants and register map of the deadzone Kalman blend smoother.
package dkbs_pkg;

    localparam int SAMPLE_BITS_DEF = 10;

    localparam int EST_FRAC = 16;
    localparam int COV_FRAC = 24;
    localparam int COV_W    = 28;
    localparam int GAIN_W   = COV_FRAC + 1;
    localparam int DEN_W    = COV_W + 1;
    localparam int DZ_W     = 10;
    localparam int PN_W     = 24;
    localparam int MN_W     = 28;
    localparam int WT_W     = 17;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam int DIV_STEPS = GAIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [COV_W-1:0]  COV_ONE    = COV_W'(1) << COV_FRAC;
    localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << COV_FRAC;
    localparam logic [WT_W-1:0]   WEIGHT_ONE = WT_W'(1) << EST_FRAC;

    localparam logic [DZ_W-1:0] DEADZONE_RST = 10'd20;
    localparam logic [PN_W-1:0] PNOISE_RST   = 24'd83886;
    localparam logic [MN_W-1:0] MNOISE_RST   = 28'd25165824;
    localparam logic [WT_W-1:0] MWEIGHT_RST  = 17'd58982;
    localparam logic [WT_W-1:0] IWEIGHT_RST  = 17'd6554;

    typedef enum logic [2:0] {
        REG_DEADZONE      = 3'd0,
        REG_PROCESS_NOISE = 3'd1,
        REG_MEAS_NOISE    = 3'd2,
        REG_MOVING_WEIGHT = 3'd3,
        REG_IDLE_WEIGHT   = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV_INIT,
        ST_DIV,
        ST_GAIN,
        ST_MUL_GAIN,
        ST_EST_ADJ,
        ST_MUL_COV,
        ST_COV_UPD,
        ST_MUL_RAW,
        ST_MUL_EST,
        ST_BLEND,
        ST_REPORT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_DECIDE,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_GAIN,
        CMD_MUL_GAIN,
        CMD_EST_ADJ,
        CMD_MUL_COV,
        CMD_COV_UPD,
        CMD_MUL_RAW,
        CMD_MUL_EST,
        CMD_BLEND,
        CMD_REPORT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_init;
        logic filt_go;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/dkbs_ctrl.sv
// Sequencing state machine of the deadzone Kalman blend smoother.
module dkbs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dkbs_pkg::dp_status_t status,
    output dkbs_pkg::dp_cmd_t    cmd
);
    import dkbs_pkg::*;

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = CMD_NOP;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = CMD_LOAD;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.op = CMD_DECIDE;
                if (status.is_init || !status.filt_go) begin
                    state_next = ST_REPORT;
                end else begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                cmd.op     = CMD_DIV_INIT;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op   = CMD_DIV_STEP;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                cmd.op     = CMD_GAIN;
                state_next = ST_MUL_GAIN;
            end
            ST_MUL_GAIN: begin
                cmd.op     = CMD_MUL_GAIN;
                state_next = ST_EST_ADJ;
            end
            ST_EST_ADJ: begin
                cmd.op     = CMD_EST_ADJ;
                state_next = ST_MUL_COV;
            end
            ST_MUL_COV: begin
                cmd.op     = CMD_MUL_COV;
                state_next = ST_COV_UPD;
            end
            ST_COV_UPD: begin
                cmd.op     = CMD_COV_UPD;
                state_next = ST_MUL_RAW;
            end
            ST_MUL_RAW: begin
                cmd.op     = CMD_MUL_RAW;
                state_next = ST_MUL_EST;
            end
            ST_MUL_EST: begin
                cmd.op     = CMD_MUL_EST;
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                cmd.op     = CMD_BLEND;
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (status.out_free) begin
                    cmd.op     = CMD_REPORT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1)) |=> state_reg == ST_GAIN)
        else $error("divider left early or late");
    a_report_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPORT && status.out_free) |=> state_reg == ST_IDLE)
        else $error("report did not return to idle");
    a_div_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_DIV) |-> $past(state_reg == ST_DIV_INIT))
        else $error("divider entered without init");
`endif

endmodule

>>> rtl/dkbs_dp.sv
// Datapath: filter state, restoring gain divider, shared multiplier and result register.
module dkbs_dp #(
    parameter int SAMPLE_BITS = dkbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [dkbs_pkg::DZ_W-1:0]     deadzone,
    input  logic [dkbs_pkg::PN_W-1:0]     process_noise,
    input  logic [dkbs_pkg::MN_W-1:0]     measurement_noise,
    input  logic [dkbs_pkg::WT_W-1:0]     moving_weight,
    input  logic [dkbs_pkg::WT_W-1:0]     idle_weight,
    input  logic                          s_op,
    input  logic [SAMPLE_BITS-1:0]        s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [SAMPLE_BITS-1:0]        m_value,
    output logic                          m_changed,
    input  dkbs_pkg::dp_cmd_t             cmd,
    output dkbs_pkg::dp_status_t          status
);
    import dkbs_pkg::*;

    localparam int EST_W  = SAMPLE_BITS + EST_FRAC;
    localparam int MB_W   = (EST_W > GAIN_W) ? EST_W : GAIN_W;
    localparam int PROD_W = COV_W + MB_W;
    localparam int CMP_W  = (SAMPLE_BITS > DZ_W) ? SAMPLE_BITS : DZ_W;

    logic                   op_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [EST_W-1:0]       est_reg;
    logic [COV_W-1:0]       cov_reg;
    logic [SAMPLE_BITS-1:0] stable_reg;
    logic [SAMPLE_BITS-1:0] last_reg;
    logic                   rvalid_reg;
    logic                   wsel_reg;
    logic [DEN_W-1:0]       denom_reg;
    logic [DEN_W-1:0]       rem_reg;
    logic [GAIN_W-1:0]      nbits_reg;
    logic [GAIN_W-1:0]      quo_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic [EST_W-1:0]       mag_reg;
    logic                   up_reg;
    logic [PROD_W-1:0]      acc_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_value_reg;
    logic                   m_changed_reg;

    logic [EST_W-1:0]       raw;
    logic [SAMPLE_BITS-1:0] delta;
    logic                   filt_go;
    logic                   above_dz;
    logic [COV_W:0]         cov_sum;
    logic [COV_W-1:0]       cov_sat;
    logic [DEN_W-1:0]       denom_sum;
    logic [DEN_W:0]         div_trial;
    logic                   div_ge;
    logic [DEN_W:0]         div_diff;
    logic [DEN_W-1:0]       div_rem;
    logic [GAIN_W-1:0]      gain_val;
    logic                   raw_ge;
    logic [EST_W-1:0]       mag_val;
    logic [WT_W-1:0]        w_sel;
    logic [WT_W-1:0]        w_clamp;
    logic [WT_W-1:0]        w_inv;
    logic [COV_W-1:0]       mul_a;
    logic [MB_W-1:0]        mul_b;
    logic [PROD_W-1:0]      product;
    logic [EST_W-1:0]       step;
    logic [PROD_W:0]        blend_sum;
    logic [EST_W-1:0]       est_blend;
    logic [COV_W-1:0]       cov_new;
    logic                   changed_val;
    logic                   out_free;

    assign raw      = {sample_reg, {EST_FRAC{1'b0}}};
    assign delta    = (sample_reg >= stable_reg) ? (sample_reg - stable_reg)
                                                 : (stable_reg - sample_reg);
    assign filt_go  = CMP_W'(delta) >= CMP_W'(deadzone);
    assign above_dz = CMP_W'(delta) > CMP_W'(deadzone);

    assign cov_sum   = {1'b0, cov_reg} + (COV_W + 1)'(process_noise);
    assign cov_sat   = cov_sum[COV_W] ? {COV_W{1'b1}} : cov_sum[COV_W-1:0];
    assign denom_sum = DEN_W'(cov_reg) + DEN_W'(measurement_noise);

    assign div_trial = {rem_reg, nbits_reg[GAIN_W-1]};
    assign div_ge    = div_trial >= (DEN_W + 1)'(denom_reg);
    assign div_diff  = div_ge ? (div_trial - (DEN_W + 1)'(denom_reg)) : div_trial;
    assign div_rem   = div_diff[DEN_W-1:0];

    assign gain_val = (denom_reg == '0) ? '0 : ((quo_reg > GAIN_ONE) ? GAIN_ONE : quo_reg);
    assign raw_ge   = raw >= est_reg;
    assign mag_val  = raw_ge ? (raw - est_reg) : (est_reg - raw);

    assign w_sel   = wsel_reg ? moving_weight : idle_weight;
    assign w_clamp = (w_sel > WEIGHT_ONE) ? WEIGHT_ONE : w_sel;
    assign w_inv   = WEIGHT_ONE - w_clamp;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            CMD_MUL_GAIN: begin
                mul_a = COV_W'(gain_reg);
                mul_b = MB_W'(mag_reg);
            end
            CMD_MUL_COV: begin
                mul_a = cov_reg;
                mul_b = MB_W'(GAIN_ONE - gain_reg);
            end
            CMD_MUL_RAW: begin
                mul_a = COV_W'(w_clamp);
                mul_b = MB_W'(raw);
            end
            CMD_MUL_EST: begin
                mul_a = COV_W'(w_inv);
                mul_b = MB_W'(est_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign step      = prod_reg[COV_FRAC +: EST_W];
    assign cov_new   = prod_reg[COV_FRAC +: COV_W];
    assign blend_sum = (PROD_W + 1)'(acc_reg) + (PROD_W + 1)'(prod_reg);
    assign est_blend = blend_sum[EST_FRAC +: EST_W];

    assign changed_val = op_reg && (!rvalid_reg || (last_reg != stable_reg));
    assign out_free    = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg     <= '0;
            cov_reg     <= COV_ONE;
            stable_reg  <= '0;
            last_reg    <= '0;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == CMD_REPORT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                CMD_DECIDE: begin
                    if (!op_reg) begin
                        est_reg    <= raw;
                        stable_reg <= sample_reg;
                    end else if (filt_go) begin
                        cov_reg <= cov_sat;
                    end
                end
                CMD_EST_ADJ: begin
                    est_reg <= up_reg ? (est_reg + step) : (est_reg - step);
                end
                CMD_COV_UPD: begin
                    cov_reg <= cov_new;
                end
                CMD_BLEND: begin
                    est_reg    <= est_blend;
                    stable_reg <= est_blend[EST_FRAC +: SAMPLE_BITS];
                end
                CMD_REPORT: begin
                    if (op_reg) begin
                        last_reg   <= stable_reg;
                        rvalid_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            CMD_LOAD: begin
                op_reg     <= s_op;
                sample_reg <= s_sample;
            end
            CMD_DECIDE: begin
                wsel_reg <= above_dz;
            end
            CMD_DIV_INIT: begin
                denom_reg <= denom_sum;
                rem_reg   <= DEN_W'(cov_reg[COV_W-1:1]);
                nbits_reg <= {cov_reg[0], {COV_FRAC{1'b0}}};
                quo_reg   <= '0;
            end
            CMD_DIV_STEP: begin
                rem_reg   <= div_rem;
                nbits_reg <= {nbits_reg[GAIN_W-2:0], 1'b0};
                quo_reg   <= {quo_reg[GAIN_W-2:0], div_ge};
            end
            CMD_GAIN: begin
                gain_reg <= gain_val;
                mag_reg  <= mag_val;
                up_reg   <= raw_ge;
            end
            CMD_MUL_GAIN, CMD_MUL_COV, CMD_MUL_RAW: begin
                prod_reg <= product;
            end
            CMD_MUL_EST: begin
                acc_reg  <= prod_reg;
                prod_reg <= product;
            end
            CMD_REPORT: begin
                m_value_reg   <= stable_reg;
                m_changed_reg <= changed_val;
            end
            default: begin
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_value   = m_value_reg;
    assign m_changed = m_changed_reg;

    assign status.is_init  = !op_reg;
    assign status.filt_go  = filt_go;
    assign status.out_free = out_free;

`ifndef SYNTHESIS
    a_gain_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CMD_GAIN) |=> gain_reg <= GAIN_ONE)
        else $error("gain above one");
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.op == CMD_REPORT))
        else $error("result raised without report");
    a_init_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CMD_REPORT && !op_reg) |=> !m_changed_reg)
        else $error("init transaction flagged as changed");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CMD_REPORT) |-> out_free)
        else $error("pending result overwritten");
`endif

endmodule

>>> rtl/deadzone_kalman_blend_smoother.sv
// Top level: configuration registers, controller and datapath of the smoother.
// Smooths unsigned converter readings. An init transaction (op 0) loads the estimate and
// the stable value from the sample and returns it with changed low.
// A filter transaction (op 1) whose distance from the stable value is below the deadzone
// repeats the stable value. Otherwise a scalar Kalman step runs: the gain
// comes from a 25-step restoring divider (one quotient bit per cycle) and four products
// share one multiplier. A new transaction is taken only after the previous result has
// been moved to the output register. A finished result waits in
// the output register while the next transaction is taken. Registers sit at byte
// addresses 0 (deadzone), 4 (process noise), 8 (measurement noise), 12 (moving weight)
// and 16 (idle weight); write them only while the block is idle.
module deadzone_kalman_blend_smoother #(
    parameter int SAMPLE_BITS = dkbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dkbs_pkg::PADDR_W-1:0] paddr,
    input  logic [dkbs_pkg::PDATA_W-1:0] pwdata,
    output logic [dkbs_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [SAMPLE_BITS-1:0]       s_sample,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [SAMPLE_BITS-1:0]       m_value,
    output logic                         m_changed
);
    import dkbs_pkg::*;

    logic [DZ_W-1:0] deadzone_reg;
    logic [PN_W-1:0] pnoise_reg;
    logic [MN_W-1:0] mnoise_reg;
    logic [WT_W-1:0] mweight_reg;
    logic [WT_W-1:0] iweight_reg;
    logic            wr_en;
    reg_idx_t        reg_idx;
    dp_cmd_t         cmd;
    dp_status_t      status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg <= DEADZONE_RST;
            pnoise_reg   <= PNOISE_RST;
            mnoise_reg   <= MNOISE_RST;
            mweight_reg  <= MWEIGHT_RST;
            iweight_reg  <= IWEIGHT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEADZONE:      deadzone_reg <= pwdata[DZ_W-1:0];
                REG_PROCESS_NOISE: pnoise_reg   <= pwdata[PN_W-1:0];
                REG_MEAS_NOISE:    mnoise_reg   <= pwdata[MN_W-1:0];
                REG_MOVING_WEIGHT: mweight_reg  <= pwdata[WT_W-1:0];
                REG_IDLE_WEIGHT:   iweight_reg  <= pwdata[WT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEADZONE:      prdata = PDATA_W'(deadzone_reg);
            REG_PROCESS_NOISE: prdata = PDATA_W'(pnoise_reg);
            REG_MEAS_NOISE:    prdata = PDATA_W'(mnoise_reg);
            REG_MOVING_WEIGHT: prdata = PDATA_W'(mweight_reg);
            REG_IDLE_WEIGHT:   prdata = PDATA_W'(iweight_reg);
            default:           prdata = '0;
        endcase
    end

    dkbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dkbs_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .deadzone          (deadzone_reg),
        .process_noise     (pnoise_reg),
        .measurement_noise (mnoise_reg),
        .moving_weight     (mweight_reg),
        .idle_weight       (iweight_reg),
        .s_op              (s_op),
        .s_sample          (s_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_value           (m_value),
        .m_changed         (m_changed),
        .cmd               (cmd),
        .status            (status)
    );

endmodule
